@@ rtl/core/cbte_pkg.sv @@
package cbte_pkg;

  // default configuration
  localparam int POINTS_DEF       = 8;
  localparam int COORD_BITS_DEF   = 16;
  localparam int CORDIC_STEPS_DEF = 16;

  // heading and parameter widths are fixed by the word format
  localparam int ANGLE_BITS = 16;
  localparam int T_BITS     = 16;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_POLY,
    S_DIV,
    S_SUM,
    S_ROT,
    S_CORDIC,
    S_DONE
  } state_t;

  // word kinds
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // cordic arctangent table, units of pi/2^31
  function automatic logic [29:0] atan_lut(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/core/cbte_in_if.sv @@
interface cbte_in_if #(
  parameter int COORD_BITS = cbte_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [15:0]                  t_param;

  modport source (output valid, kind, point_x, point_y, t_param, input ready);
  modport sink   (input valid, kind, point_x, point_y, t_param, output ready);
endinterface

@@ rtl/core/cbte_out_if.sv @@
interface cbte_out_if #(
  parameter int COORD_BITS = cbte_pkg::COORD_BITS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pos_x;
  logic signed [COORD_BITS-1:0] pos_y;
  logic signed [15:0]           heading;
  logic                         degenerate;

  modport source (output valid, pos_x, pos_y, heading, degenerate, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, degenerate, output ready);
endinterface

@@ rtl/core/cubic_bspline_track_evaluator_top.sv @@
// channel | dir | payload                              | word
// in_ch   | in  | kind, point_x, point_y, t_param      | push point or evaluate at t
// out_ch  | out | pos_x, pos_y, heading, degenerate    | one per evaluate word
//
// push word: accepted while idle, window shifts, no result
// evaluate word: result computed through states POLY, DIV, SUM, ROT, CORDIC and DONE;
//   ready again once the sequencer returns to idle; a zero tangent skips
//   the cordic loop; uses the shared multiplier, the byte-wide divide-by-3 and cordic
// rst (synchronous) clears the window, sequencer and output valid
// a result waiting on out_ch does not block new words; a finished result waits for it
module cubic_bspline_track_evaluator_top #(
  parameter int POINTS       = cbte_pkg::POINTS_DEF,
  parameter int COORD_BITS   = cbte_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STEPS = cbte_pkg::CORDIC_STEPS_DEF
) (
  input logic     clk,
  input logic     rst,
  cbte_in_if.sink   in_ch,
  cbte_out_if.source out_ch
);
  import cbte_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int MA    = 35;
  localparam int MB    = (CB + 2 > 18) ? CB + 2 : 18;
  localparam int PW    = MA + MB;
  localparam int AW    = CB + 33;
  localparam int DW    = CB + 19;
  localparam int CW    = DW + 2;
  localparam int ZW    = 34;
  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;

  state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] dsel;

  // control point window
  logic signed [CB-1:0] pts_x [POINTS];
  logic signed [CB-1:0] pts_y [POINTS];
  logic signed [CB-1:0] win_x [4];
  logic signed [CB-1:0] win_y [4];

  // polynomial terms
  logic [16:0] tq, uq;
  logic [32:0] t2, u2;
  logic [48:0] t3, u3;
  logic [51:0] r1;
  logic [17:0] q0, q2, q1;
  logic [30:0] w0, w1, w3, w2;
  logic [30:0] wv [4];
  logic [17:0] qv [3];

  // shared multiplier
  logic signed [MA-1:0] ma;
  logic signed [MB-1:0] mb;
  logic signed [PW-1:0] prod;

  // divide-by-3 unit
  logic [31:0] dv, qacc, dsrc;
  logic [1:0]  drem;
  logic [7:0]  qbyte;
  logic [1:0]  rbyte;

  // accumulators
  logic signed [AW-1:0] ax, ay;
  logic signed [DW-1:0] dx, dy;

  // cordic
  logic signed [CW-1:0] cx, cy;
  logic signed [ZW-1:0] cz;
  logic                 degen;

  logic in_ready, out_load;
  logic in_acc;
  logic [4:0] op_o, op_k;
  logic [1:0] sk, dk;

  assign in_acc = in_ch.valid && in_ready;

  for (genvar g = 0; g < 4; g++) begin : g_win
    assign win_x[g] = pts_x[g];
    assign win_y[g] = pts_y[g];
  end

  assign w2 = 31'(32'd1 << 30) - w0 - w1 - w3;
  assign q1 = 18'(1 << 17) - q0 - q2;
  assign wv[0] = w0;
  assign wv[1] = w1;
  assign wv[2] = w2;
  assign wv[3] = w3;
  assign qv[0] = q0;
  assign qv[1] = q1;
  assign qv[2] = q2;

  // r1 = 4*2^48 + 3*t^3 - 6*2^16*t^2
  assign r1 = (52'd1 << 50) + (52'(t3) << 1) + 52'(t3) - (52'(t2) << 17) - (52'(t2) << 18);

  // rounded dividend, already scaled by 2^-19
  always_comb begin
    logic [51:0] v;
    unique case (dsel)
      2'd0:    v = 52'(u3);
      2'd1:    v = 52'(t3);
      default: v = r1;
    endcase
    v = v + (52'd3 << 18);
    dsrc = v[50:19];
  end

  // eight bits of the divide-by-3 in one cycle
  always_comb begin
    logic [2:0] rr;
    logic [1:0] r;
    r = drem;
    qbyte = '0;
    for (int b = 7; b >= 0; b--) begin
      rr = {r, dv[24 + b]};
      if (rr >= 3'd3) begin
        qbyte[b] = 1'b1;
        rr = rr - 3'd3;
      end
      r = rr[1:0];
    end
    rbyte = r;
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (in_acc && in_ch.kind == KIND_EVAL) state_next = S_POLY;
      end
      S_POLY: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd4) begin
          state_next = S_DIV;
          cnt_next   = '0;
        end
      end
      S_DIV: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd4) begin
          cnt_next = '0;
          if (dsel == 2'd2) state_next = S_SUM;
        end
      end
      S_SUM: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd14) begin
          state_next = S_ROT;
          cnt_next   = '0;
        end
      end
      S_ROT: begin
        cnt_next   = '0;
        state_next = (dx == '0 && dy == '0) ? S_DONE : S_CORDIC;
      end
      S_CORDIC: begin
        cnt_next = cnt + 5'd1;
        if (cnt == 5'(STEPS - 1)) begin
          state_next = S_DONE;
          cnt_next   = '0;
        end
      end
      S_DONE: begin
        if (!out_ch.valid || out_ch.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs and multiplier operands
  assign op_k = cnt - 5'd8;
  assign sk   = cnt[2:1];
  assign dk   = op_k[2:1];
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    ma = '0;
    mb = '0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_POLY: begin
        unique case (cnt[1:0])
          2'd0: begin
            ma = MA'($signed({1'b0, tq}));
            mb = MB'($signed({1'b0, tq}));
          end
          2'd1: begin
            ma = MA'($signed({1'b0, uq}));
            mb = MB'($signed({1'b0, uq}));
          end
          2'd2: begin
            ma = MA'($signed({1'b0, t2}));
            mb = MB'($signed({1'b0, tq}));
          end
          default: begin
            ma = MA'($signed({1'b0, u2}));
            mb = MB'($signed({1'b0, uq}));
          end
        endcase
      end
      S_SUM: begin
        if (cnt < 5'd8) begin
          ma = MA'($signed({1'b0, wv[sk]}));
          mb = cnt[0] ? MB'(win_y[sk]) : MB'(win_x[sk]);
        end else if (cnt < 5'd14) begin
          ma = MA'($signed({1'b0, qv[dk]}));
          mb = op_k[0] ? MB'(win_y[dk + 2'd1]) - MB'(win_y[dk])
                       : MB'(win_x[dk + 2'd1]) - MB'(win_x[dk]);
        end
      end
      S_DONE: out_load = !out_ch.valid || out_ch.ready;
      default: ;
    endcase
  end

  assign in_ch.ready = in_ready;
  assign op_o = cnt - 5'd1;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      dsel  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (state == S_IDLE) dsel <= '0;
      else if (state == S_DIV && cnt == 5'd4) dsel <= dsel + 2'd1;
    end
  end

  // control point window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < POINTS; i++) begin
        pts_x[i] <= '0;
        pts_y[i] <= '0;
      end
    end else if (in_acc && in_ch.kind == KIND_PUSH) begin
      for (int i = 0; i < POINTS - 1; i++) begin
        pts_x[i] <= pts_x[i + 1];
        pts_y[i] <= pts_y[i + 1];
      end
      pts_x[POINTS-1] <= in_ch.point_x;
      pts_y[POINTS-1] <= in_ch.point_y;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod <= PW'(ma) * PW'(mb);
    if (in_acc) begin
      tq <= {1'b0, in_ch.t_param};
      uq <= 17'h10000 - {1'b0, in_ch.t_param};
    end
    if (state == S_POLY) begin
      unique case (cnt[2:0])
        3'd1: t2 <= prod[32:0];
        3'd2: u2 <= prod[32:0];
        3'd3: t3 <= prod[48:0];
        3'd4: begin
          u3 <= prod[48:0];
          q0 <= 18'((34'(u2) + 34'd32768) >> 16);
          q2 <= 18'((34'(t2) + 34'd32768) >> 16);
        end
        default: ;
      endcase
    end
    if (state == S_DIV) begin
      if (cnt == 5'd0) begin
        dv   <= dsrc;
        drem <= '0;
        qacc <= '0;
      end else begin
        dv   <= dv << 8;
        drem <= rbyte;
        qacc <= {qacc[23:0], qbyte};
        if (cnt == 5'd4) begin
          unique case (dsel)
            2'd0:    w0 <= {qacc[22:0], qbyte};
            2'd1:    w3 <= {qacc[22:0], qbyte};
            default: w1 <= {qacc[22:0], qbyte};
          endcase
        end
      end
    end
    if (state == S_SUM) begin
      if (cnt == 5'd0) begin
        ax <= '0;
        ay <= '0;
        dx <= '0;
        dy <= '0;
      end else if (op_o < 5'd8) begin
        if (op_o[0]) ay <= ay + $signed(prod[AW-1:0]);
        else         ax <= ax + $signed(prod[AW-1:0]);
      end else begin
        if (op_o[0]) dy <= dy + $signed(prod[DW-1:0]);
        else         dx <= dx + $signed(prod[DW-1:0]);
      end
    end
    if (state == S_ROT) begin
      degen <= (dx == '0 && dy == '0);
      if (dx > 0) begin
        if (dy >= 0) begin
          cx <= CW'(dy);
          cy <= CW'(dx);
          cz <= ZW'(34'sd1 <<< 30);
        end else begin
          cx <= -CW'(dy);
          cy <= -CW'(dx);
          cz <= -ZW'(34'sd1 <<< 30);
        end
      end else begin
        cx <= -CW'(dx);
        cy <= CW'(dy);
        cz <= '0;
      end
    end
    if (state == S_CORDIC) begin
      if (cy > 0) begin
        cx <= cx + (cy >>> cnt);
        cy <= cy - (cx >>> cnt);
        cz <= cz + ZW'(atan_lut(cnt));
      end else begin
        cx <= cx - (cy >>> cnt);
        cy <= cy + (cx >>> cnt);
        cz <= cz - ZW'(atan_lut(cnt));
      end
    end
  end

  // rounding, saturation and heading scaling
  logic signed [AW-1:0] rx, ry;
  logic signed [AW-1:0] sat_hi, sat_lo;
  logic signed [CB-1:0] px, py;
  logic signed [ZW-1:0] zr;

  assign sat_hi = $signed({{(AW - CB + 1){1'b0}}, {(CB - 1){1'b1}}});
  assign sat_lo = ~sat_hi;
  assign rx = (ax + (AW'(1) <<< 29)) >>> 30;
  assign ry = (ay + (AW'(1) <<< 29)) >>> 30;
  assign px = (rx > sat_hi) ? CB'(sat_hi) : (rx < sat_lo) ? CB'(sat_lo) : CB'(rx);
  assign py = (ry > sat_hi) ? CB'(sat_hi) : (ry < sat_lo) ? CB'(sat_lo) : CB'(ry);
  assign zr = (cz + ZW'(32768)) >>> 16;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.pos_x      <= px;
      out_ch.pos_y      <= py;
      out_ch.heading    <= degen ? '0 : $signed(zr[15:0]);
      out_ch.degenerate <= degen;
    end
  end

  // checks
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.kind == KIND_EVAL) |=> !in_ch.ready)
    else $error("ready while evaluating");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.degenerate) |-> out_ch.heading == 16'sd0)
    else $error("degenerate result with nonzero heading");

  a_push_silent: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.kind == KIND_PUSH && !out_ch.ready) |=> $stable(out_ch.valid))
    else $error("push word changed output valid");

endmodule
